>>> hw/rtl/prle_pkg.sv
// Shared widths, limits and the write-group record type of the PackBits encoder.
package prle_pkg;

  localparam int unsigned POS_W       = 17;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_WR      = 4;
  localparam int unsigned WR_CNT_W    = 3;
  localparam int unsigned OFF_W       = 3;
  localparam int unsigned MAX_BLOCK   = 128;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // All writes caused by one source byte, positions already resolved.
  typedef struct packed {
    logic [WR_CNT_W-1:0]            n;
    logic [MAX_WR-1:0][POS_W-1:0]   pos;
    logic [MAX_WR-1:0][BYTE_W-1:0]  data;
    logic                           done;
    logic [POS_W-1:0]               total;
  } rec_t;

endpackage

>>> hw/rtl/prle_front.sv
// Front end: accepts source bytes, runs the run/literal coder and builds one write group.
module prle_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [prle_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_last,
  output logic                              push,
  output prle_pkg::rec_t                    push_rec
);

  localparam int unsigned PW = prle_pkg::POS_W;
  localparam int unsigned BW = prle_pkg::BYTE_W;
  localparam int unsigned OW = prle_pkg::OFF_W;
  localparam int unsigned NW = prle_pkg::WR_CNT_W;
  localparam int unsigned MW = prle_pkg::MAX_WR;
  localparam logic [BW-1:0] MAX_BLK = BW'(prle_pkg::MAX_BLOCK);
  localparam logic [BW-1:0] LIT_RUN_MIN = 8'd3;

  // Working copy of the coder state; positions are offsets from write_pos.
  typedef struct packed {
    logic [BW-1:0]             rv;
    logic [BW-1:0]             rl;
    logic                      lo;
    logic [BW-1:0]             lc;
    logic                      hp_old;
    logic [OW-1:0]             hp_off;
    logic [OW-1:0]             off;
    logic [NW-1:0]             n;
    logic [MW-1:0]             e_hp;
    logic [MW-1:0][OW-1:0]     e_off;
    logic [MW-1:0][BW-1:0]     e_byte;
  } work_t;

  logic [BW-1:0] rv_r, rv_nxt;
  logic [BW-1:0] rl_r, rl_nxt;
  logic          lo_r, lo_nxt;
  logic [PW-1:0] hp_r, hp_nxt;
  logic [BW-1:0] lc_r, lc_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic          acc;
  work_t         w;

  function automatic work_t f_emit(work_t wi, logic sel_hp, logic [OW-1:0] o,
                                   logic [BW-1:0] b);
    work_t r;
    r = wi;
    if (wi.n < NW'(MW)) begin
      r.e_hp[wi.n[1:0]]   = sel_hp;
      r.e_off[wi.n[1:0]]  = o;
      r.e_byte[wi.n[1:0]] = b;
      r.n                 = wi.n + 3'd1;
    end
    return r;
  endfunction

  function automatic work_t f_close(work_t wi);
    work_t r;
    r = wi;
    if (wi.lo) begin
      r    = f_emit(wi, wi.hp_old, wi.hp_off, (wi.lc != '0) ? wi.lc - 8'd1 : '0);
      r.lo = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t f_lit(work_t wi, logic written, logic [BW-1:0] b);
    work_t r;
    logic  wr;
    r  = wi;
    wr = written;
    if (!r.lo) begin
      r.hp_old = 1'b0;
      r.hp_off = r.off;
      r.off    = r.off + 3'd1;
      r.lc     = '0;
      r.lo     = 1'b1;
      wr       = 1'b0;
    end
    if (!wr) r = f_emit(r, 1'b0, r.off, b);
    r.off = r.off + 3'd1;
    r.lc  = r.lc + 8'd1;
    if (r.lc >= MAX_BLK) r = f_close(r);
    return r;
  endfunction

  function automatic work_t f_run(work_t wi, logic [BW-1:0] k);
    work_t r;
    r     = f_emit(wi, 1'b0, wi.off, 8'd1 - k);
    r     = f_emit(r, 1'b0, r.off + 3'd1, r.rv);
    r.off = r.off + 3'd2;
    return r;
  endfunction

  function automatic work_t f_resolve(work_t wi);
    work_t r;
    logic  wr;
    r  = wi;
    wr = wi.lo;
    for (int i = 0; i < 2; i++) begin
      if (r.rl != '0) begin
        if (r.lo && r.rl < LIT_RUN_MIN) begin
          r    = f_lit(r, wr, r.rv);
          wr   = 1'b0;
          r.rl = r.rl - 8'd1;
        end else if (r.rl >= 8'd2) begin
          r    = f_close(r);
          r    = f_run(r, r.rl);
          r.rl = '0;
        end else begin
          r    = f_lit(r, 1'b0, r.rv);
          r.rl = '0;
        end
      end
    end
    return r;
  endfunction

  assign acc = in_valid && in_ready;

  always_comb begin
    w        = '0;
    w.rv     = rv_r;
    w.rl     = rl_r;
    w.lo     = lo_r;
    w.lc     = lc_r;
    w.hp_old = 1'b1;
    if (rl_r != '0 && in_byte == rv_r) begin
      w.rl = w.rl + 8'd1;
      if (w.lo && w.rl >= LIT_RUN_MIN) w = f_close(w);
      if (w.rl >= MAX_BLK) begin
        if (w.lo && w.rl < LIT_RUN_MIN) begin
          w    = f_lit(w, 1'b1, w.rv);
          w.rl = w.rl - 8'd1;
          if (w.lo && w.rl != '0) w = f_emit(w, 1'b0, w.off, w.rv);
        end else begin
          w    = f_close(w);
          w    = f_run(w, w.rl);
          w.rl = '0;
        end
      end
    end else begin
      w    = f_resolve(w);
      w.rv = in_byte;
      w.rl = 8'd1;
      if (w.lo) w = f_emit(w, 1'b0, w.off, in_byte);
    end
    if (in_last) begin
      w = f_resolve(w);
      w = f_close(w);
    end
  end

  always_comb begin
    push_rec.n     = w.n;
    push_rec.done  = in_last;
    push_rec.total = wp_r + PW'(w.off);
    for (int i = 0; i < MW; i++) begin
      push_rec.pos[i]  = w.e_hp[i] ? hp_r : wp_r + PW'(w.e_off[i]);
      push_rec.data[i] = w.e_byte[i];
    end
  end

  assign push = acc && (w.n != '0);

  always_comb begin
    rv_nxt = rv_r;
    rl_nxt = rl_r;
    lo_nxt = lo_r;
    hp_nxt = hp_r;
    lc_nxt = lc_r;
    wp_nxt = wp_r;
    if (acc) begin
      if (in_last) begin
        rv_nxt = '0;
        rl_nxt = '0;
        lo_nxt = 1'b0;
        hp_nxt = '0;
        lc_nxt = '0;
        wp_nxt = '0;
      end else begin
        rv_nxt = w.rv;
        rl_nxt = w.rl;
        lo_nxt = w.lo;
        lc_nxt = w.lc;
        hp_nxt = w.hp_old ? hp_r : wp_r + PW'(w.hp_off);
        wp_nxt = wp_r + PW'(w.off);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
      rl_r <= '0;
      lo_r <= 1'b0;
      hp_r <= '0;
      lc_r <= '0;
      wp_r <= '0;
    end else begin
      rv_r <= rv_nxt;
      rl_r <= rl_nxt;
      lo_r <= lo_nxt;
      hp_r <= hp_nxt;
      lc_r <= lc_nxt;
      wp_r <= wp_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> (wp_r == '0 && rl_r == '0 && !lo_r))
    else $error("coder state not cleared after final byte");

  a_lit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r |-> (lc_r < MAX_BLK && rl_r < LIT_RUN_MIN))
    else $error("open literal block holds a full block or a long run");

  a_run_capped: assert property (@(posedge clk) disable iff (!rst_n)
    rl_r < MAX_BLK)
    else $error("pending run reached the block limit");

endmodule

>>> hw/rtl/prle_queue.sv
// Short queue of write groups between the coder and the output serializer.
module prle_queue #(
  parameter int unsigned DEPTH = prle_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  prle_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output prle_pkg::rec_t  head_rec
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  prle_pkg::rec_t   mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("write group pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> hw/rtl/prle_back.sv
// Back end: drives the writes of the head group one request per cycle while out_tready is high.
module prle_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   head_valid,
  input  prle_pkg::rec_t                         head_rec,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [prle_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tuser
);

  localparam int unsigned IW = $clog2(prle_pkg::MAX_WR);
  localparam int unsigned PW = prle_pkg::POS_W;
  localparam int unsigned BW = prle_pkg::BYTE_W;
  localparam int unsigned PAD_W = prle_pkg::OUT_TDATA_W - 2 * PW - BW;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          grp_end;

  assign grp_end    = ({1'b0, idx_r} == head_rec.n - 3'd1);
  assign out_tvalid = head_valid;
  assign out_tlast  = grp_end;
  assign out_tuser  = grp_end && head_rec.done;
  assign out_tdata  = {{PAD_W{1'b0}}, head_rec.total, head_rec.data[idx_r],
                       head_rec.pos[idx_r]};
  assign pop        = head_valid && out_tready && grp_end;

  always_comb begin
    idx_nxt = idx_r;
    if (head_valid && out_tready) idx_nxt = grp_end ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head_rec.n != '0 && head_rec.n <= 3'd4))
    else $error("queued write group has a bad write count");

  a_idx_in_grp: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head_rec.n))
    else $error("write index past end of group");

endmodule

>>> hw/rtl/packbits_run_length_encoder.sv
// Top level of the PackBits run-length encoder: coder, group queue and write serializer.
//
//  channel | dir | fields (tdata from bit 0 up)                  | tlast      | tuser
//  in_     | in  | data_byte[7:0]                                | last_byte  | -
//  out_    | out | out_pos[16:0] out_byte[24:17] total_len[41:25]| out_last   | stream_done
//
// One source byte is taken per cycle while the group queue has a free slot.
// Each byte yields 0..4 writes; the serializer drives one write request per cycle
// while out_tready is high.
// Queue holds QUEUE_DEPTH write groups, so either side may stall on its own.
// Synchronous active-low reset, no clearing pass.
module packbits_run_length_encoder #(
  parameter int unsigned QUEUE_DEPTH = prle_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [prle_pkg::IN_TDATA_W-1:0]       in_tdata,   // data_byte[7:0]
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [prle_pkg::OUT_TDATA_W-1:0]      out_tdata,  // out_pos, out_byte, total_length
  output logic                                  out_tlast,
  output logic                                  out_tuser   // stream_done
);

  logic           q_full;
  logic           push;
  prle_pkg::rec_t push_rec;
  logic           pop;
  logic           head_valid;
  prle_pkg::rec_t head_rec;

  assign in_tready = !q_full;

  prle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata[prle_pkg::BYTE_W-1:0]),
    .in_last  (in_tlast),
    .push     (push),
    .push_rec (push_rec)
  );

  prle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  prle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PackBits encoder: directed and random byte streams vs a predictor.
module tb_top;

  localparam int CYCLE_LIMIT    = 4000000;
  localparam int PLAN_ROWS      = 13;
  localparam int RANDOM_ITEMS   = 320;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [prle_pkg::POS_W-1:0]  pos;
    logic [prle_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        done;
    logic [prle_pkg::POS_W-1:0]  total;
  } write_t;

  typedef struct packed {
    logic [7:0]  first;
    logic [7:0]  incr;
    logic [8:0]  reps;
    logic        fin;
    logic        typed;
    logic [16:0] p0;
    logic [7:0]  b0;
    logic [16:0] p1;
    logic [7:0]  b1;
    logic [16:0] tot;
  } plan_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [prle_pkg::IN_TDATA_W-1:0]  in_tdata;   // data_byte[7:0]
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  // out_pos[16:0], out_byte[24:17], total_length[41:25]
  logic [prle_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             out_tuser;  // stream_done

  packbits_run_length_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // encoder state mirror
  logic [7:0]                 run_val;
  int unsigned                run_len;
  bit                         lit_open;
  logic [prle_pkg::POS_W-1:0] lit_hdr_pos;
  int unsigned                lit_cnt;
  logic [prle_pkg::POS_W-1:0] wr_pos;

  write_t    step_wr[$];
  write_t    pending_writes[$];
  write_t    typed_writes[$];
  bit        typed_on;
  plan_row_t plan [PLAN_ROWS];
  write_t    got;
  write_t    want;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        tx_quiet;
  bit        rx_quiet;
  bit        press_req;

  function automatic void reset_coder();
    run_val     = '0;
    run_len     = 0;
    lit_open    = 1'b0;
    lit_hdr_pos = '0;
    lit_cnt     = 0;
    wr_pos      = '0;
  endfunction

  function automatic void put_write(logic [prle_pkg::POS_W-1:0] p, logic [7:0] b);
    write_t w;
    if (step_wr.size() >= prle_pkg::MAX_WR) return;
    w = '0;
    w.pos = p;
    w.data = b;
    step_wr.push_back(w);
  endfunction

  function automatic void close_lit();
    if (!lit_open) return;
    put_write(lit_hdr_pos, (lit_cnt != 0) ? 8'(lit_cnt - 1) : 8'h00);
    lit_open = 1'b0;
  endfunction

  // written: byte already sits at wr_pos from the speculative write
  function automatic void lit_append(bit written, logic [7:0] v);
    if (!lit_open) begin
      lit_hdr_pos = wr_pos;
      wr_pos = wr_pos + 1'b1;
      lit_cnt = 0;
      lit_open = 1'b1;
      written = 1'b0;
    end
    if (!written) put_write(wr_pos, v);
    wr_pos = wr_pos + 1'b1;
    lit_cnt++;
    if (lit_cnt >= prle_pkg::MAX_BLOCK) close_lit();
  endfunction

  function automatic void run_out(int unsigned k);
    put_write(wr_pos, 8'(257 - k));
    put_write(wr_pos + 1'b1, run_val);
    wr_pos = wr_pos + 2'd2;
  endfunction

  function automatic void flush_run();
    bit pre_written;
    pre_written = lit_open;
    while (run_len > 0) begin
      if (lit_open && run_len < 3) begin
        lit_append(pre_written, run_val);
        pre_written = 1'b0;
        run_len--;
      end else if (run_len >= 2) begin
        close_lit();
        run_out(run_len);
        run_len = 0;
      end else begin
        lit_append(1'b0, run_val);
        run_len = 0;
      end
    end
  endfunction

  function automatic void encode_byte(logic [7:0] v, logic fin);
    logic [prle_pkg::POS_W-1:0] len;
    write_t w;
    step_wr.delete();
    if (run_len > 0 && v == run_val) begin
      run_len++;
      if (lit_open && run_len >= 3) close_lit();
      if (run_len >= prle_pkg::MAX_BLOCK) begin
        if (lit_open && run_len < 3) begin
          lit_append(1'b1, run_val);
          run_len--;
          if (lit_open && run_len > 0) put_write(wr_pos, run_val);
        end else begin
          close_lit();
          run_out(run_len);
          run_len = 0;
        end
      end
    end else begin
      flush_run();
      run_val = v;
      run_len = 1;
      if (lit_open) put_write(wr_pos, v);
    end
    if (fin) begin
      flush_run();
      close_lit();
    end
    len = wr_pos;
    if (fin) reset_coder();
    foreach (step_wr[i]) begin
      w = step_wr[i];
      w.total = len;
      w.last = (i == step_wr.size() - 1);
      w.done = fin && w.last;
      step_wr[i] = w;
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (tx_quiet || $urandom_range(0, 1) == 1) return 0;
    return gap_len();
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_byte(input logic [7:0] d, input logic l, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic random_frames(input int target);
    logic [7:0] frame[$];
    logic [7:0] v;
    logic [7:0] tail;
    logic [7:0] base;
    int sent;
    int fcnt;
    int len;
    int r;
    bit pressed;
    sent = 0;
    fcnt = 0;
    tail = 8'h00;
    pressed = 1'b0;
    while (sent < target) begin
      frame.delete();
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (fcnt == 0) begin
        // run past the block cap
        v = 8'($urandom_range(0, 255));
        len = $urandom_range(prle_pkg::MAX_BLOCK, 200);
        repeat (len) frame.push_back(v);
      end else if (fcnt == 1) begin
        // literal past the block cap
        v = 8'($urandom_range(0, 255));
        len = $urandom_range(prle_pkg::MAX_BLOCK, 140);
        repeat (len) begin
          v = v ^ 8'($urandom_range(1, 255));
          frame.push_back(v);
        end
      end else if (!pressed && sent >= target / 3) begin
        // receiver holds off while the sender keeps offering
        pressed = 1'b1;
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        press_req = 1'b1;
        repeat (40) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            v = ($urandom_range(0, 1) == 1) ? tail : 8'($urandom_range(0, 255));
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 6);
            repeat (len) frame.push_back(v);
          end else if (r < 9) begin
            base = 8'($urandom_range(0, 255));
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 1) begin
              repeat (len) frame.push_back(base + 8'($urandom_range(0, 2)));
            end else begin
              repeat (len) frame.push_back(8'($urandom_range(0, 255)));
            end
          end else begin
            base = 8'($urandom_range(0, 255));
            v = 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) begin
              frame.push_back(base);
              frame.push_back(base);
              frame.push_back(v);
              frame.push_back(v);
            end
          end
          tail = frame[$];
        end
      end
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, tx_gap());
      sent += frame.size();
      fcnt++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // receiver side
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (press_req) begin
        press_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 9) < 3) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // predict on each input request, check each output request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      encode_byte(in_tdata, in_tlast);
      if (typed_on) begin
        foreach (typed_writes[i]) pending_writes.push_back(typed_writes[i]);
        typed_on = 1'b0;
      end else begin
        foreach (step_wr[i]) pending_writes.push_back(step_wr[i]);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.pos   = out_tdata[16:0];
      got.data  = out_tdata[24:17];
      got.total = out_tdata[41:25];
      got.last  = out_tlast;
      got.done  = out_tuser;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write pos=%h byte=%h total=%h last=%b done=%b",
                 $time, got.pos, got.data, got.total, got.last, got.done);
        err_cnt++;
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          $display("%0t: write mismatch, expected pos=%h byte=%h total=%h last=%b done=%b, %s",
                   $time, want.pos, want.data, want.total, want.last, want.done,
                   $sformatf("got pos=%h byte=%h total=%h last=%b done=%b",
                             got.pos, got.data, got.total, got.last, got.done));
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [7:0] d;
    logic       l;
    write_t     w;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    tx_quiet  = 1'b0;
    rx_quiet  = 1'b0;
    press_req = 1'b0;
    typed_on  = 1'b0;
    reset_coder();
    plan = '{
      '{8'h00, 8'h00, 9'd1, 1'b1, 1'b1, 17'd1, 8'h00, 17'd0, 8'h00, 17'd2},
      '{8'hFF, 8'h00, 9'd1, 1'b1, 1'b1, 17'd1, 8'hFF, 17'd0, 8'h00, 17'd2},
      '{8'hAA, 8'h00, 9'd1, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'hAA, 8'h00, 9'd1, 1'b1, 1'b1, 17'd0, 8'hFF, 17'd1, 8'hAA, 17'd2},
      '{8'h01, 8'h01, 9'd3, 1'b1, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h10, 8'h01, 9'd2, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h55, 8'h00, 9'd3, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h20, 8'h00, 9'd1, 1'b1, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h30, 8'h01, 9'd2, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h77, 8'h00, 9'd2, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h31, 8'h00, 9'd1, 1'b1, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'h80, 8'h7F, 9'd2, 1'b0, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0},
      '{8'hFF, 8'h00, 9'd2, 1'b1, 1'b0, 17'd0, 8'h00, 17'd0, 8'h00, 17'd0}
    };
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        d = plan[r].first + 8'(k) * plan[r].incr;
        l = plan[r].fin && (k == plan[r].reps - 1);
        if (plan[r].typed && l) begin
          typed_writes.delete();
          w = '0;
          w.pos = plan[r].p0;
          w.data = plan[r].b0;
          w.total = plan[r].tot;
          typed_writes.push_back(w);
          w.pos = plan[r].p1;
          w.data = plan[r].b1;
          w.last = 1'b1;
          w.done = 1'b1;
          typed_writes.push_back(w);
          typed_on = 1'b1;
        end
        send_byte(d, l, tx_gap());
      end
    end

    random_frames(RANDOM_ITEMS);
    in_tvalid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/prle_pkg.sv
hw/rtl/prle_front.sv
hw/rtl/prle_queue.sv
hw/rtl/prle_back.sv
hw/rtl/packbits_run_length_encoder.sv
tb/tb_top.sv
